[hw/rtl/smi_pkg.sv]
// ----------------------------------------------------------------------------
// smi_pkg: shared types for the spatial metric inverse
// Status codes and the flag bundle passed from the front end to the top level.
// ----------------------------------------------------------------------------
package smi_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ZERO_LAPSE = 2'd1,
    STATUS_ZERO_DET   = 2'd2,
    STATUS_SAT        = 2'd3
  } status_e;

  typedef struct packed {
    logic valid;
    logic sat;
  } flags_t;

endpackage

[hw/rtl/smi_qmul.sv]
// ----------------------------------------------------------------------------
// smi_qmul: registered fixed point multiplier
// Sign-magnitude product, rounded half away from zero, saturated to the word.
// ----------------------------------------------------------------------------
module smi_qmul #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic signed [W-1:0] p_o,
  output logic                sat_o
);

  localparam int PW = 2 * W;
  localparam int QW = 2 * W - F;
  localparam logic [PW-1:0] HALF    = PW'(1) << (F - 1);
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

  logic          neg;
  logic [W-1:0]  ma, mb, mm;
  logic [PW-1:0] prod, sum;
  logic [QW-1:0] mq, lim;
  logic          sat;
  logic signed [W-1:0] p_d, p_q;
  logic          sat_q;

  assign neg  = a_i[W-1] ^ b_i[W-1];
  assign ma   = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mb   = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign prod = PW'(ma) * PW'(mb);
  assign sum  = prod + HALF;
  assign mq   = sum[PW-1:F];
  assign lim  = neg ? LIM_NEG : LIM_POS;
  assign sat  = mq > lim;
  assign mm   = sat ? lim[W-1:0] : mq[W-1:0];
  assign p_d  = neg ? -$signed(mm) : $signed(mm);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      sat_q <= sat;
    end
  end

  assign p_o   = p_q;
  assign sat_o = sat_q;

endmodule

[hw/rtl/smi_front.sv]
// ----------------------------------------------------------------------------
// smi_front: cofactor and determinant pipeline
// Five register stages: input, metric products, cofactors, determinant
// products, determinant sum.
// ----------------------------------------------------------------------------
module smi_front import smi_pkg::*; #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] lapse_i,
  input  logic signed [W-1:0] g_xx_i,
  input  logic signed [W-1:0] g_xy_i,
  input  logic signed [W-1:0] g_xz_i,
  input  logic signed [W-1:0] g_yy_i,
  input  logic signed [W-1:0] g_yz_i,
  input  logic signed [W-1:0] g_zz_i,
  output flags_t              flags_o,
  output logic signed [W-1:0] lapse_o,
  output logic signed [W-1:0] det_o,
  output logic [5:0][W-1:0]   cof_o
);

  function automatic logic [W-1:0] mag(logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic [W:0] pack(logic neg, logic [W:0] m);
    logic [W:0]   lim;
    logic         sat;
    logic [W-1:0] mm;
    lim = neg ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
    sat = m > lim;
    mm  = sat ? lim[W-1:0] : m[W-1:0];
    return {sat, (neg ? W'(-mm) : mm)};
  endfunction

  function automatic logic [W:0] qadd(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                      logic neg_b);
    logic         na, nb, rn;
    logic [W-1:0] ma, mb;
    logic [W:0]   m;
    na = a[W-1];
    nb = b[W-1] ^ neg_b;
    ma = mag(a);
    mb = mag(b);
    if (na == nb) begin
      m  = {1'b0, ma} + {1'b0, mb};
      rn = na;
    end else if (ma >= mb) begin
      m  = {1'b0, ma - mb};
      rn = na;
    end else begin
      m  = {1'b0, mb - ma};
      rn = nb;
    end
    return pack(rn, m);
  endfunction

  // stage 1: input registers
  logic                v1_q;
  logic signed [W-1:0] lapse1_q, xx1_q, xy1_q, xz1_q, yy1_q, yz1_q, zz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lapse1_q <= lapse_i;
      xx1_q    <= g_xx_i;
      xy1_q    <= g_xy_i;
      xz1_q    <= g_xz_i;
      yy1_q    <= g_yy_i;
      yz1_q    <= g_yz_i;
      zz1_q    <= g_zz_i;
    end
  end

  // stage 2: metric products, cofactor order xx, yy, zz, xy, xz, yz
  logic signed [W-1:0] pa [12];
  logic signed [W-1:0] pb [12];
  logic signed [W-1:0] p2 [12];
  logic [11:0]         s2;
  logic                v2_q;
  logic signed [W-1:0] lapse2_q, xx2_q, xy2_q, xz2_q;

  always_comb begin
    pa[0]  = yy1_q; pb[0]  = zz1_q;
    pa[1]  = yz1_q; pb[1]  = yz1_q;
    pa[2]  = xx1_q; pb[2]  = zz1_q;
    pa[3]  = xz1_q; pb[3]  = xz1_q;
    pa[4]  = xx1_q; pb[4]  = yy1_q;
    pa[5]  = xy1_q; pb[5]  = xy1_q;
    pa[6]  = xz1_q; pb[6]  = yz1_q;
    pa[7]  = xy1_q; pb[7]  = zz1_q;
    pa[8]  = xy1_q; pb[8]  = yz1_q;
    pa[9]  = yy1_q; pb[9]  = xz1_q;
    pa[10] = xy1_q; pb[10] = xz1_q;
    pa[11] = xx1_q; pb[11] = yz1_q;
  end

  for (genvar k = 0; k < 12; k++) begin : g_prod
    smi_qmul #(.W(W), .F(F)) u_mul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (pa[k]),
      .b_i   (pb[k]),
      .p_o   (p2[k]),
      .sat_o (s2[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lapse2_q <= lapse1_q;
      xx2_q    <= xx1_q;
      xy2_q    <= xy1_q;
      xz2_q    <= xz1_q;
    end
  end

  // stage 3: cofactors
  logic [W:0]          add3 [6];
  logic                sat3_d;
  logic                v3_q, sat3_q;
  logic signed [W-1:0] c3_q [6];
  logic signed [W-1:0] lapse3_q, xx3_q, xy3_q, xz3_q;

  always_comb begin
    sat3_d = |s2;
    for (int j = 0; j < 6; j++) begin
      add3[j] = qadd(p2[2*j], p2[2*j+1], 1'b1);
      sat3_d  = sat3_d | add3[j][W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 6; j++) begin
        c3_q[j] <= add3[j][W-1:0];
      end
      sat3_q   <= sat3_d;
      lapse3_q <= lapse2_q;
      xx3_q    <= xx2_q;
      xy3_q    <= xy2_q;
      xz3_q    <= xz2_q;
    end
  end

  // stage 4: determinant products
  logic signed [W-1:0] q4 [3];
  logic [2:0]          s4;
  logic                v4_q, sat4_q;
  logic signed [W-1:0] c4_q [6];
  logic signed [W-1:0] lapse4_q;

  smi_qmul #(.W(W), .F(F)) u_det_xx (
    .clk_i (clk_i), .en_i (en_i), .a_i (xx3_q), .b_i (c3_q[0]),
    .p_o   (q4[0]), .sat_o (s4[0])
  );
  smi_qmul #(.W(W), .F(F)) u_det_xy (
    .clk_i (clk_i), .en_i (en_i), .a_i (xy3_q), .b_i (c3_q[3]),
    .p_o   (q4[1]), .sat_o (s4[1])
  );
  smi_qmul #(.W(W), .F(F)) u_det_xz (
    .clk_i (clk_i), .en_i (en_i), .a_i (xz3_q), .b_i (c3_q[4]),
    .p_o   (q4[2]), .sat_o (s4[2])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q     <= c3_q;
      sat4_q   <= sat3_q;
      lapse4_q <= lapse3_q;
    end
  end

  // stage 5: determinant sum
  logic [W:0]          d1, d2;
  logic                v5_q, sat5_q;
  logic signed [W-1:0] c5_q [6];
  logic signed [W-1:0] lapse5_q, det5_q;

  assign d1 = qadd(q4[0], q4[1], 1'b0);
  assign d2 = qadd(d1[W-1:0], q4[2], 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c5_q     <= c4_q;
      sat5_q   <= sat4_q | (|s4) | d1[W] | d2[W];
      lapse5_q <= lapse4_q;
      det5_q   <= d2[W-1:0];
    end
  end

  assign flags_o.valid = v5_q;
  assign flags_o.sat   = sat5_q;
  assign lapse_o       = lapse5_q;
  assign det_o         = det5_q;

  for (genvar j = 0; j < 6; j++) begin : g_cof
    assign cof_o[j] = c5_q[j];
  end

endmodule

[hw/rtl/smi_div.sv]
// ----------------------------------------------------------------------------
// smi_div: pipelined fixed point divider
// Restoring division, one quotient bit per stage, then round half away from
// zero and saturate.
// ----------------------------------------------------------------------------
module smi_div #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic signed [W-1:0] quo_o,
  output logic                sat_o
);

  localparam int NB = W + F;
  localparam logic [NB:0] LIM_NEG = (NB+1)'(1) << (W - 1);
  localparam logic [NB:0] LIM_POS = LIM_NEG - (NB+1)'(1);

  logic [W:0]    r_q   [NB];
  logic [NB-1:0] q_q   [NB];
  logic [NB-1:0] n_q   [NB];
  logic [W-1:0]  d_q   [NB];
  logic          neg_q [NB];

  logic [W-1:0] num_mag, den_mag;

  assign num_mag = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign den_mag = den_i[W-1] ? W'(-den_i) : W'(den_i);

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [W:0]    r_in, t;
    logic [NB-1:0] q_in, n_in;
    logic [W-1:0]  d_in;
    logic          neg_in, ge;

    if (k == 0) begin : g_first
      assign r_in   = '0;
      assign q_in   = '0;
      assign n_in   = {num_mag, {F{1'b0}}};
      assign d_in   = den_mag;
      assign neg_in = num_i[W-1] ^ den_i[W-1];
    end else begin : g_next
      assign r_in   = r_q[k-1];
      assign q_in   = q_q[k-1];
      assign n_in   = n_q[k-1];
      assign d_in   = d_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign t  = {r_in[W-1:0], n_in[NB-1-k]};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? t - {1'b0, d_in} : t;
        q_q[k]   <= {q_in[NB-2:0], ge};
        n_q[k]   <= n_in;
        d_q[k]   <= d_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  logic [W:0]    r_l, d_l;
  logic          rnd;
  logic [NB:0]   qr, lim;
  logic          sat;
  logic [W-1:0]  mm;
  logic signed [W-1:0] quo_q;
  logic          sat_q;

  assign r_l = r_q[NB-1];
  assign d_l = {1'b0, d_q[NB-1]};
  assign rnd = r_l >= (d_l - r_l);
  assign qr  = {1'b0, q_q[NB-1]} + (NB+1)'(rnd);
  assign lim = neg_q[NB-1] ? LIM_NEG : LIM_POS;
  assign sat = qr > lim;
  assign mm  = sat ? lim[W-1:0] : qr[W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= neg_q[NB-1] ? -$signed(mm) : $signed(mm);
      sat_q <= sat;
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_q;

endmodule

[hw/rtl/smi_sqrt.sv]
// ----------------------------------------------------------------------------
// smi_sqrt: pipelined integer square root
// One root bit per stage by the remainder method; later stages only hold the
// result.
// ----------------------------------------------------------------------------
module smi_sqrt #(
  parameter int W     = 32,
  parameter int F     = 24,
  parameter int DEPTH = 57
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-2:0] rad_i,
  output logic [W-2:0] root_o
);

  localparam int SB = (W + F) / 2;
  localparam int RW = 2 * SB;

  logic [RW-1:0] rem_q  [DEPTH];
  logic [SB-1:0] root_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_step
    logic [RW-1:0] rem_in, rem_out;
    logic [SB-1:0] root_in, root_out;

    if (k == 0) begin : g_first
      assign rem_in  = RW'({rad_i, {F{1'b0}}});
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    if (k < SB) begin : g_bit
      localparam int B = SB - 1 - k;
      logic [RW-1:0] trial;
      logic          ge;
      assign trial    = ({{SB{1'b0}}, root_in} << (B + 1)) | (RW'(1) << (2 * B));
      assign ge       = rem_in >= trial;
      assign rem_out  = ge ? rem_in - trial : rem_in;
      assign root_out = ge ? (root_in | (SB'(1) << B)) : root_in;
    end else begin : g_hold
      assign rem_out  = rem_in;
      assign root_out = root_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_out;
        root_q[k] <= root_out;
      end
    end
  end

  assign root_o = (W-1)'(root_q[DEPTH-1]);

endmodule

[hw/rtl/spatial_metric_inverse.sv]
// ----------------------------------------------------------------------------
// spatial_metric_inverse: lapse reciprocal, determinant and inverse of a
// symmetric 3x3 metric in signed fixed point
// Q8.24 by default; the dividers resolve one bit per stage. Throughput is one
// transaction per cycle while the output is not stalled.
// A stalled output fills a skid register, then holds the whole pipeline.
// Reset clears every valid bit; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module spatial_metric_inverse import smi_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // lapse, g_xx, g_xy, g_xz, g_yy, g_yz, g_zz
  input  logic [((7*WORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // lapse_recip, lapse_recip_sq, det_abs, det_sqrt, inv_xx, inv_xy, inv_xz,
  // inv_yy, inv_yz, inv_zz, status
  output logic [((10*WORD_BITS+6)/8)*8-1:0] m_axis_tdata
);

  localparam int W       = WORD_BITS;
  localparam int F       = FRAC_BITS;
  localparam int OUT_W   = ((10 * WORD_BITS + 6) / 8) * 8;
  localparam int DIV_LAT = W + F + 1;
  localparam logic [W-1:0] ONE_Q   = W'(1) << F;
  localparam logic [W-2:0] POS_LIM = '1;

  logic en;

  // front end
  flags_t              fr_flags;
  logic signed [W-1:0] fr_lapse, fr_det;
  logic [5:0][W-1:0]   fr_cof;

  smi_front #(.W(W), .F(F)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .lapse_i (s_axis_tdata[0*W +: W]),
    .g_xx_i  (s_axis_tdata[1*W +: W]),
    .g_xy_i  (s_axis_tdata[2*W +: W]),
    .g_xz_i  (s_axis_tdata[3*W +: W]),
    .g_yy_i  (s_axis_tdata[4*W +: W]),
    .g_yz_i  (s_axis_tdata[5*W +: W]),
    .g_zz_i  (s_axis_tdata[6*W +: W]),
    .flags_o (fr_flags),
    .lapse_o (fr_lapse),
    .det_o   (fr_det),
    .cof_o   (fr_cof)
  );

  logic         det_min, lapse_zero, det_zero;
  logic [W-1:0] det_mag;
  logic [W-2:0] dabs;

  assign det_mag    = fr_det[W-1] ? W'(-fr_det) : W'(fr_det);
  assign det_min    = det_mag[W-1];
  assign dabs       = det_min ? POS_LIM : det_mag[W-2:0];
  assign lapse_zero = fr_lapse == '0;
  assign det_zero   = fr_det == '0;

  // dividers and square root
  logic signed [W-1:0] inv_num [6];
  logic signed [W-1:0] inv_div [6];
  logic [5:0]          inv_sat;
  logic signed [W-1:0] rcp_div;
  logic                rcp_sat;
  logic [W-2:0]        dsq;

  always_comb begin
    inv_num[0] = fr_cof[0];
    inv_num[1] = fr_cof[3];
    inv_num[2] = fr_cof[4];
    inv_num[3] = fr_cof[1];
    inv_num[4] = fr_cof[5];
    inv_num[5] = fr_cof[2];
  end

  smi_div #(.W(W), .F(F)) u_rcp (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ONE_Q),
    .den_i (fr_lapse),
    .quo_o (rcp_div),
    .sat_o (rcp_sat)
  );

  for (genvar k = 0; k < 6; k++) begin : g_inv
    smi_div #(.W(W), .F(F)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (inv_num[k]),
      .den_i (fr_det),
      .quo_o (inv_div[k]),
      .sat_o (inv_sat[k])
    );
  end

  smi_sqrt #(.W(W), .F(F), .DEPTH(DIV_LAT)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (dabs),
    .root_o (dsq)
  );

  // side band alongside the dividers
  logic [DIV_LAT-1:0] sb_v_q, sb_sat_q, sb_lz_q, sb_dz_q;
  logic [W-2:0]       sb_dabs_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= '0;
    end else if (en) begin
      sb_v_q <= {sb_v_q[DIV_LAT-2:0], fr_flags.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_sat_q     <= {sb_sat_q[DIV_LAT-2:0], fr_flags.sat | det_min};
      sb_lz_q      <= {sb_lz_q[DIV_LAT-2:0], lapse_zero};
      sb_dz_q      <= {sb_dz_q[DIV_LAT-2:0], det_zero};
      sb_dabs_q[0] <= dabs;
      for (int j = 1; j < DIV_LAT; j++) begin
        sb_dabs_q[j] <= sb_dabs_q[j-1];
      end
    end
  end

  // final stage: reciprocal square and masking
  logic                lz_l, dz_l;
  logic signed [W-1:0] rcp2_p;
  logic                rcp2_sat;
  logic                fv_q, fsat_q, flz_q, fdz_q;
  logic signed [W-1:0] frcp_q;
  logic signed [W-1:0] finv_q [6];
  logic [W-2:0]        fdabs_q, fdsq_q;

  assign lz_l = sb_lz_q[DIV_LAT-1];
  assign dz_l = sb_dz_q[DIV_LAT-1];

  smi_qmul #(.W(W), .F(F)) u_rcp_sq (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (rcp_div),
    .b_i   (rcp_div),
    .p_o   (rcp2_p),
    .sat_o (rcp2_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en) begin
      fv_q <= sb_v_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fsat_q  <= sb_sat_q[DIV_LAT-1] | (!lz_l & rcp_sat) | (!dz_l & (|inv_sat));
      flz_q   <= lz_l;
      fdz_q   <= dz_l;
      frcp_q  <= lz_l ? '0 : rcp_div;
      fdabs_q <= sb_dabs_q[DIV_LAT-1];
      fdsq_q  <= dsq;
      for (int j = 0; j < 6; j++) begin
        finv_q[j] <= dz_l ? '0 : inv_div[j];
      end
    end
  end

  status_e          status;
  logic [W-2:0]     rcp2;
  logic             sat_all;
  logic [OUT_W-1:0] item;

  assign rcp2    = flz_q ? '0 : rcp2_p[W-2:0];
  assign sat_all = fsat_q | (!flz_q & rcp2_sat);

  always_comb begin
    if (flz_q) begin
      status = STATUS_ZERO_LAPSE;
    end else if (fdz_q) begin
      status = STATUS_ZERO_DET;
    end else if (sat_all) begin
      status = STATUS_SAT;
    end else begin
      status = STATUS_OK;
    end
  end

  assign item = OUT_W'({status, finv_q[5], finv_q[4], finv_q[3], finv_q[2], finv_q[1],
                        finv_q[0], fdsq_q, fdabs_q, rcp2, frcp_q});

  // output register and skid
  logic             out_v_q, skid_v_q, push, pop;
  logic [OUT_W-1:0] out_q, skid_q;

  assign en   = !skid_v_q;
  assign push = en & fv_q;
  assign pop  = out_v_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      out_v_q  <= skid_v_q | push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      out_q <= skid_v_q ? skid_q : item;
    end else if (push) begin
      skid_q <= item;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for spatial_metric_inverse
// Streams lapse and metric items through the block with random gaps and
// output stalls. A model of the fixed point arithmetic predicts each result,
// and the model's result is checked field by field against the block's.
// ----------------------------------------------------------------------------
module tb_top import smi_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB = 32;
  localparam int FB = 24;
  localparam int IN_W = ((7*WB+7)/8)*8;
  localparam int OUT_W = ((10*WB+6)/8)*8;
  localparam int NFIELD = 11;
  localparam int FIELD_W [NFIELD] = '{32, 31, 31, 31, 32, 32, 32, 32, 32, 32, 2};
  localparam string FIELD_NAME [NFIELD] = '{"lapse_recip", "lapse_recip_sq",
    "det_abs", "det_sqrt", "inv_xx", "inv_xy", "inv_xz", "inv_yy", "inv_yz",
    "inv_zz", "status"};
  localparam longint ONE = longint'(1) << FB;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [OUT_W-1:0] inverse_q[$];
  int               mismatches;
  bit               idle_en;
  bit               sat_seen;
  int               stall_left;

  spatial_metric_inverse dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [127:0] magn(longint v);
    return {64'd0, (v < 0) ? 64'(-v) : 64'(v)};
  endfunction

  function automatic longint clamp(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) begin
      sat_seen = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = magn(a) * magn(b);
    p = (p + (128'd1 << (FB-1))) >> FB;
    return clamp((a < 0) != (b < 0), p);
  endfunction

  function automatic longint fx_sub(longint a, longint b, bit neg_b);
    bit na, nb;
    logic [127:0] ma, mb;
    na = a < 0;
    nb = (b < 0) != neg_b;
    ma = magn(a);
    mb = magn(b);
    if (na == nb) return clamp(na, ma + mb);
    if (ma >= mb) return clamp(na, ma - mb);
    return clamp(nb, mb - ma);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    logic [127:0] n, d, q, r;
    n = magn(num) << FB;
    d = magn(den);
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return clamp((num < 0) != (den < 0), q);
  endfunction

  function automatic logic [127:0] int_sqrt(logic [127:0] n);
    logic [127:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] predict_inverse(logic [IN_W-1:0] d);
    longint lapse, xx, xy, xz, yy, yz, zz;
    longint rcp, rcp2, det, dabs, dsq, cxx, cyy, czz, cxy, cxz, cyz;
    longint inv [6];
    status_e st;
    logic [OUT_W-1:0] res;
    sat_seen = 1'b0;
    lapse = longint'($signed(d[0*WB +: WB]));
    xx = longint'($signed(d[1*WB +: WB]));
    xy = longint'($signed(d[2*WB +: WB]));
    xz = longint'($signed(d[3*WB +: WB]));
    yy = longint'($signed(d[4*WB +: WB]));
    yz = longint'($signed(d[5*WB +: WB]));
    zz = longint'($signed(d[6*WB +: WB]));
    rcp = 0;
    rcp2 = 0;
    if (lapse != 0) begin
      rcp = fx_div(ONE, lapse);
      rcp2 = fx_mul(rcp, rcp);
    end
    cxx = fx_sub(fx_mul(yy, zz), fx_mul(yz, yz), 1'b1);
    cyy = fx_sub(fx_mul(xx, zz), fx_mul(xz, xz), 1'b1);
    czz = fx_sub(fx_mul(xx, yy), fx_mul(xy, xy), 1'b1);
    cxy = fx_sub(fx_mul(xz, yz), fx_mul(xy, zz), 1'b1);
    cxz = fx_sub(fx_mul(xy, yz), fx_mul(yy, xz), 1'b1);
    cyz = fx_sub(fx_mul(xy, xz), fx_mul(xx, yz), 1'b1);
    det = fx_sub(fx_mul(xx, cxx), fx_mul(xy, cxy), 1'b0);
    det = fx_sub(det, fx_mul(xz, cxz), 1'b0);
    dabs = clamp(1'b0, magn(det));
    dsq = clamp(1'b0, int_sqrt(magn(dabs) << FB));
    foreach (inv[k]) inv[k] = 0;
    if (det != 0) begin
      inv[0] = fx_div(cxx, det);
      inv[1] = fx_div(cxy, det);
      inv[2] = fx_div(cxz, det);
      inv[3] = fx_div(cyy, det);
      inv[4] = fx_div(cyz, det);
      inv[5] = fx_div(czz, det);
    end
    if (lapse == 0) st = STATUS_ZERO_LAPSE;
    else if (det == 0) st = STATUS_ZERO_DET;
    else if (sat_seen) st = STATUS_SAT;
    else st = STATUS_OK;
    res = '0;
    res[31:0] = rcp[31:0];
    res[62:32] = rcp2[30:0];
    res[93:63] = dabs[30:0];
    res[124:94] = dsq[30:0];
    for (int k = 0; k < 6; k++) res[125 + 32*k +: 32] = inv[k][31:0];
    res[318:317] = st;
    return res;
  endfunction

  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    logic [31:0] a, e;
    int off;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = inverse_q.pop_front();
        off = 0;
        for (int f = 0; f < NFIELD; f++) begin
          a = 32'(m_axis_tdata >> off) & 32'((64'd1 << FIELD_W[f]) - 1);
          e = 32'(want >> off) & 32'((64'd1 << FIELD_W[f]) - 1);
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s mismatch: expected %h actual %h", FIELD_NAME[f], e, a);
          end
          off += FIELD_W[f];
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_metric(logic [31:0] lapse, logic [31:0] xx, logic [31:0] xy,
                             logic [31:0] xz, logic [31:0] yy, logic [31:0] yz,
                             logic [31:0] zz);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tdata = {zz, yz, yy, xz, xy, xx, lapse};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    inverse_q.push_back(predict_inverse(s_axis_tdata));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (inverse_q.size() > 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_off_diag();
    return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
  endfunction

  function automatic logic [31:0] rand_diag();
    return $urandom_range(1 << 23, 1 << 26);
  endfunction

  function automatic logic [31:0] rand_lapse();
    logic [31:0] v;
    v = $urandom_range(1 << 20, 1 << 26);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic test_directed();
    logic [31:0] one, mx, mn;
    one = 32'(ONE);
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_metric(one, one, 0, 0, one, 0, one);
    send_metric(0, one, 0, 0, one, 0, one);
    send_metric(one, 0, 0, 0, 0, 0, 0);
    send_metric(0, 0, 0, 0, 0, 0, 0);
    send_metric(-one, one, one, one, one, one, one);
    send_metric(1, one, 0, 0, one, 0, one);
    send_metric(32'hFFFF_FFFF, one, 0, 0, one, 0, one);
    send_metric(mx, mx, mx, mx, mx, mx, mx);
    send_metric(mn, mn, mn, mn, mn, mn, mn);
    send_metric(mx, mx, 0, 0, mx, 0, mx);
    send_metric(mn, mn, 0, 0, mn, 0, mn);
    send_metric(one, -one, 0, 0, one, 0, one);
    send_metric(one, 2*one, one, 0, 2*one, one, 2*one);
    send_metric(one, one, 0, 0, one, 0, 1);
    send_metric(one, 1, 0, 0, 1, 0, 1);
    send_metric(one, 0, one, 0, one, 0, one);
    send_metric(2*one, one/2, 0, 0, one/4, 0, 4*one);
    send_metric(one, 128*one, 0, 0, 128*one, 0, 64*one);
  endtask

  task automatic test_wellformed(int n);
    for (int i = 0; i < n; i++)
      send_metric(rand_lapse(), rand_diag(), rand_off_diag(), rand_off_diag(),
                  rand_diag(), rand_off_diag(), rand_diag());
  endtask

  task automatic test_noise(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1))
        send_metric($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
      else
        send_metric($urandom_range(0, 3) == 0 ? 32'd0 : 32'($signed($urandom) >>> 8),
                    32'($signed($urandom) >>> 6), 32'($signed($urandom) >>> 6),
                    32'($signed($urandom) >>> 6), 32'($signed($urandom) >>> 6),
                    32'($signed($urandom) >>> 6), 32'($signed($urandom) >>> 6));
    end
  endtask

  task automatic test_pause_drain();
    test_wellformed(20);
    drain_results();
    test_wellformed(20);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    stall_left = 0;
    idle_en = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_wellformed(350);
    test_pause_drain();
    test_noise(200);
    idle_en = 1'b0;
    test_wellformed(60);
    test_noise(40);
    drain_results();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0)
      $display("spatial_metric_inverse test passed");
    else
      $display("spatial_metric_inverse test failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("spatial_metric_inverse test failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/smi_pkg.sv
hw/rtl/smi_qmul.sv
hw/rtl/smi_front.sv
hw/rtl/smi_div.sv
hw/rtl/smi_sqrt.sv
hw/rtl/spatial_metric_inverse.sv
dv/tb_top.sv
